### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("assertion failed");

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, ck, rs, cond)
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons)

`endif

`endif

### rtl/core/ppd_pkg.sv
`default_nettype none

package ppd_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_COUNT_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Coefficient register, unsigned Q4.8
  localparam int COEFF_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam logic [COEFF_BITS-1:0] COEFF_RESET = 12'd512;

  // Result queue depth; an item may push two results at once
  localparam int FIFO_DEPTH = 4;

  typedef enum logic {
    KIND_PEAK    = 1'b0,
    KIND_SUMMARY = 1'b1
  } ppd_kind_t;

  // Write strobes from the judge to the result queue
  typedef struct packed {
    logic first;
    logic second;
  } ppd_push_t;

endpackage

`default_nettype wire

### rtl/core/plateau_peak_detector_unit.sv
// Plateau peak detector.
// Input channel: one sample per request on sample_level, with last_sample
// set on the final sample of a packet. A request is taken when in_valid is
// high and in_stall is low.
// Output channel: result requests taken when out_valid is high and out_stall
// is low. A peak result (result_kind 0) carries level and plateau centre; the
// summary (result_kind 1, last_result 1) carries the packet's peak count.
// Configuration: coeff_q8 is written when cfg_valid and cfg_ready are high;
// write it only while no packet is in flight.
// Throughput: one sample per cycle while the queue has room. The sample
// is held in the input register, judged there and pushed into a
// four-entry result queue, whose head drives the output combinationally.
// A peak on the final sample gives two results, which leave one at a time.
// The input stalls while fewer than two queue entries are free, so the input
// rate is set by the single read port of the result queue.
// Reset (rst, synchronous) empties the queue, clears the packet state and
// loads the coefficient with 2.0. A stalled output holds its result; the
// queue keeps accepting samples until it is nearly full.
`default_nettype none

module plateau_peak_detector_unit
  import ppd_pkg::*;
#(
  parameter int MAX_COUNT   = MAX_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [SAMPLE_BITS-1:0]         sample_level,
  input  wire logic                           last_sample,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [COEFF_BITS-1:0]          coeff_q8,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                result_kind,
  output logic [SAMPLE_BITS-1:0]              peak_level,
  output logic [$clog2(MAX_COUNT)-1:0]        peak_position,
  output logic [$clog2(MAX_COUNT + 1)-1:0]    peak_total,
  output logic                                last_result
);

  localparam int POS_W = $clog2(MAX_COUNT);
  localparam int CNT_W = $clog2(MAX_COUNT + 1);
  localparam int RES_W = 2 + SAMPLE_BITS + POS_W + CNT_W;

  logic [COEFF_BITS-1:0] coeff;
  logic                  room;
  ppd_push_t             push;
  logic [RES_W-1:0]      res_first;
  logic [RES_W-1:0]      res_second;
  logic [RES_W-1:0]      head;

  // Hold the coefficient register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coeff <= COEFF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      coeff <= coeff_q8;
    end
  end

  ppd_judge #(
    .MAX_COUNT   (MAX_COUNT),
    .SAMPLE_BITS (SAMPLE_BITS),
    .POS_W       (POS_W),
    .CNT_W       (CNT_W),
    .RES_W       (RES_W)
  ) u_judge (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_level (sample_level),
    .last_sample  (last_sample),
    .coeff        (coeff),
    .room         (room),
    .push         (push),
    .res_first    (res_first),
    .res_second   (res_second)
  );

  ppd_result_fifo #(
    .RES_W (RES_W)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .res_first  (res_first),
    .res_second (res_second),
    .room       (room),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .head       (head)
  );

  // Split the queue head into the result fields
  assign {result_kind, peak_level, peak_position, peak_total, last_result} = head;

endmodule

`default_nettype wire

### rtl/core/ppd_judge.sv
`default_nettype none

`include "assert_macros.svh"

module ppd_judge
  import ppd_pkg::*;
#(
  parameter int MAX_COUNT   = MAX_COUNT_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int POS_W       = $clog2(MAX_COUNT),
  parameter int CNT_W       = $clog2(MAX_COUNT + 1),
  parameter int RES_W       = 2 + SAMPLE_BITS + POS_W + CNT_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] sample_level,
  input  wire logic                   last_sample,
  input  wire logic [COEFF_BITS-1:0]  coeff,
  input  wire logic                   room,
  output ppd_push_t                   push,
  output logic [RES_W-1:0]            res_first,
  output logic [RES_W-1:0]            res_second
);

  localparam int PROD_W = COEFF_BITS + SAMPLE_BITS;

  // Input register
  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_last;

  // Packet state
  logic [SAMPLE_BITS-1:0] older_sample, older_sample_next;
  logic [SAMPLE_BITS-1:0] newer_sample, newer_sample_next;
  logic [CNT_W-1:0]       sample_position, sample_position_next;
  logic                   rising_seen, rising_seen_next;
  logic [POS_W-1:0]       rise_position, rise_position_next;
  logic [CNT_W-1:0]       peak_counter, peak_counter_next;

  logic             consume;
  logic             active;
  logic             judge;
  logic             rise_now;
  logic             rising_eff;
  logic [POS_W-1:0] judged_pos;
  logic [POS_W-1:0] rise_eff;
  logic [POS_W:0]   pos_sum;
  logic [POS_W-1:0] centre;
  logic             close_now;
  logic [PROD_W-1:0] lhs_prev;
  logic [PROD_W-1:0] lhs_next;
  logic [PROD_W-1:0] rhs;
  logic             peak_hit;
  logic [CNT_W-1:0] total;
  logic [RES_W-1:0] peak_res;
  logic [RES_W-1:0] summary_res;

  assign consume  = s1_valid && room;
  assign in_stall = s1_valid && !room;

  // Load the input register whenever it is free or drains
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_sample <= sample_level;
      s1_last   <= last_sample;
    end
  end

  // Judge the middle sample against both neighbors
  always_comb begin
    active     = sample_position < CNT_W'(MAX_COUNT);
    judge      = active && (sample_position >= CNT_W'(2));
    judged_pos = POS_W'(sample_position - CNT_W'(1));
    rise_now   = older_sample < newer_sample;
    rising_eff = rising_seen || rise_now;
    rise_eff   = rise_now ? judged_pos : rise_position;
    pos_sum    = {1'b0, rise_eff} + {1'b0, judged_pos};
    centre     = pos_sum[POS_W:1];
    close_now  = judge && rising_eff && (newer_sample > s1_sample);
    lhs_prev   = PROD_W'(coeff) * PROD_W'(older_sample);
    lhs_next   = PROD_W'(coeff) * PROD_W'(s1_sample);
    rhs        = PROD_W'({newer_sample, {FRAC_BITS{1'b0}}});
    peak_hit   = close_now && (lhs_prev > rhs) && (lhs_next > rhs);
    total      = peak_counter + CNT_W'(peak_hit);
  end

  // Advance the packet state
  always_comb begin
    older_sample_next    = older_sample;
    newer_sample_next    = newer_sample;
    sample_position_next = sample_position;
    rising_seen_next     = rising_seen;
    rise_position_next   = rise_position;
    peak_counter_next    = peak_counter;
    if (judge) begin
      rising_seen_next   = rising_eff && !close_now;
      rise_position_next = rise_eff;
    end
    if (active) begin
      older_sample_next    = newer_sample;
      newer_sample_next    = s1_sample;
      sample_position_next = sample_position + CNT_W'(1);
      peak_counter_next    = total;
    end
    if (s1_last) begin
      sample_position_next = '0;
      rising_seen_next     = 1'b0;
      peak_counter_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample    <= '0;
      newer_sample    <= '0;
      sample_position <= '0;
      rising_seen     <= 1'b0;
      rise_position   <= '0;
      peak_counter    <= '0;
    end else if (consume) begin
      older_sample    <= older_sample_next;
      newer_sample    <= newer_sample_next;
      sample_position <= sample_position_next;
      rising_seen     <= rising_seen_next;
      rise_position   <= rise_position_next;
      peak_counter    <= peak_counter_next;
    end
  end

  // Build the results: the peak comes before the summary
  always_comb begin
    peak_res    = {KIND_PEAK, newer_sample, centre, CNT_W'(0), 1'b0};
    summary_res = {KIND_SUMMARY, SAMPLE_BITS'(0), POS_W'(0), total, 1'b1};
    res_first   = peak_hit ? peak_res : summary_res;
    res_second  = summary_res;
    push.first  = consume && (peak_hit || s1_last);
    push.second = consume && peak_hit && s1_last;
  end

  `ASSERT_IMPLY(a_second_needs_first, clk, rst, push.second, push.first)
  `ASSERT_IMPLY(a_rise_after_two, clk, rst, rising_seen, sample_position >= CNT_W'(3))
  `ASSERT_ALWAYS(a_count_bounded, clk, rst, peak_counter <= sample_position)

endmodule

`default_nettype wire

### rtl/core/ppd_result_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module ppd_result_fifo
  import ppd_pkg::*;
#(
  parameter int RES_W = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ppd_push_t        push,
  input  wire logic [RES_W-1:0] res_first,
  input  wire logic [RES_W-1:0] res_second,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [RES_W-1:0]      head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [RES_W-1:0] slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && !out_stall;
  assign room      = count <= CNT_W'(FIFO_DEPTH - 2);
  assign head      = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr + PTR_W'(push.first) + PTR_W'(push.second);
    count_next  = count + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);
  end

  // Write up to two requests per cycle
  always_ff @(posedge clk) begin
    if (push.first) begin
      slots[wr_ptr] <= res_first;
    end
    if (push.second) begin
      slots[wr_ptr + PTR_W'(1)] <= res_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, count <= CNT_W'(FIFO_DEPTH))
  `ASSERT_IMPLY(a_push_has_room, clk, rst, push.first, count <= CNT_W'(FIFO_DEPTH - 2))

endmodule

`default_nettype wire
